// ===== rtl/mrsb_pkg.sv =====
package mrsb_pkg;

    localparam int COORD_BITS = 16;
    localparam int RUN_BITS   = 7;
    localparam int STATE_BITS = COORD_BITS + 2;
    localparam int CALC_BITS  = STATE_BITS + 2;
    localparam int FIFO_DEPTH = 3;
    localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);
    localparam int CFG_IDX_BITS = 3;

    localparam logic OP_START = 1'b0;
    localparam logic OP_CODE  = 1'b1;

    localparam logic [7:0] CODE_END = 8'h80;
    localparam logic [7:0] CODE_ROW = 8'h00;

    typedef logic signed [STATE_BITS-1:0] state_t;
    typedef logic signed [CALC_BITS-1:0]  calc_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CLIP_ENABLE = 3'd0,
        REG_CLIP_LEFT   = 3'd1,
        REG_CLIP_TOP    = 3'd2,
        REG_CLIP_WIDTH  = 3'd3,
        REG_CLIP_HEIGHT = 3'd4,
        REG_FILL_COLOR  = 3'd5
    } cfg_index_e;

    typedef struct packed {
        logic               opcode;
        logic [7:0]         code_byte;
        logic signed [15:0] place_x;
        logic signed [15:0] place_y;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic [14:0]        box_width;
        logic [14:0]        box_height;
    } in_word_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] fill_x;
        logic signed [COORD_BITS-1:0] fill_y;
        logic [RUN_BITS-1:0]          fill_length;
        logic                         end_of_sprite;
    } out_word_t;

    typedef struct packed {
        logic               clip_enable;
        logic signed [15:0] clip_left;
        logic signed [15:0] clip_top;
        logic [14:0]        clip_width;
        logic [14:0]        clip_height;
    } clip_cfg_t;

endpackage

// ===== rtl/mrsb_decode.sv =====
module mrsb_decode
    import mrsb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  in_word_t  item,
    input  clip_cfg_t cfg,
    output logic      res_valid,
    output out_word_t res
);

    state_t column_reg, column_next;
    state_t row_reg, row_next;
    state_t right_reg, right_next;
    logic   clipping_reg, clipping_next;

    calc_t right, left, top, bw, bh;
    calc_t cl, ct, cw, ch;
    calc_t x_right, x_left, row_ext, len;
    logic  start_clip, run_inside;

    always_comb
    begin
        cl = calc_t'(cfg.clip_left);
        ct = calc_t'(cfg.clip_top);
        cw = calc_t'(cfg.clip_width);
        ch = calc_t'(cfg.clip_height);

        // placement of a new sprite, mirrored about the anchor
        bw    = calc_t'(item.box_width);
        bh    = calc_t'(item.box_height);
        right = calc_t'(item.place_x) - calc_t'(item.offset_x);
        left  = right - bw + calc_t'(1);
        top   = calc_t'(item.place_y) + calc_t'(item.offset_y);
        start_clip = cfg.clip_enable &&
                     ((cl > left) || (cl + cw < right + calc_t'(1)) ||
                      (ct > top) || (top + bh > ct + ch));

        // run ends at the current column and extends leftwards
        len     = calc_t'({1'b0, item.code_byte});
        x_right = calc_t'(column_reg);
        x_left  = x_right - len + calc_t'(1);
        row_ext = calc_t'(row_reg);
        run_inside = (ct <= row_ext) && (row_ext <= ct + ch - calc_t'(1)) &&
                     (cl <= x_left) && (x_right <= cl + cw - calc_t'(1));

        column_next   = column_reg;
        row_next      = row_reg;
        right_next    = right_reg;
        clipping_next = clipping_reg;
        res_valid     = 1'b0;
        res           = '0;

        if (item_valid)
        begin
            if (item.opcode == OP_START)
            begin
                clipping_next = start_clip;
                right_next    = state_t'(right);
                column_next   = state_t'(right);
                row_next      = state_t'(top);
            end
            else if (item.code_byte == CODE_END)
            begin
                res_valid         = 1'b1;
                res.end_of_sprite = 1'b1;
            end
            else if (item.code_byte[7])
            begin
                column_next = state_t'(x_right - calc_t'({1'b0, item.code_byte[6:0]}));
            end
            else if (item.code_byte == CODE_ROW)
            begin
                column_next = right_reg;
                row_next    = state_t'(row_ext + calc_t'(1));
            end
            else
            begin
                column_next     = state_t'(x_right - len);
                res_valid       = !clipping_reg || run_inside;
                res.fill_x      = x_left[COORD_BITS-1:0];
                res.fill_y      = row_reg[COORD_BITS-1:0];
                res.fill_length = item.code_byte[RUN_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg   <= '0;
            row_reg      <= '0;
            right_reg    <= '0;
            clipping_reg <= 1'b0;
        end
        else
        begin
            column_reg   <= column_next;
            row_reg      <= row_next;
            right_reg    <= right_next;
            clipping_reg <= clipping_next;
        end
    end

endmodule

// ===== rtl/mrsb_out_fifo.sv =====
module mrsb_out_fifo
    import mrsb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  out_word_t           push_data,
    input  logic                pop,
    output logic                not_empty,
    output out_word_t           head,
    output logic [CNT_BITS-1:0] count
);

    out_word_t             mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  do_pop;

    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign count     = count_reg;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + PTR_BITS'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + PTR_BITS'(1);
        count_next = count_reg + CNT_BITS'(push) - CNT_BITS'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/mirrored_rle_sprite_run_blitter_top.sv =====
// Mirrored one-color RLE sprite run generator. A start word (opcode 0) places the sprite
// and decides whether runs must be tested against the clip window; each code word (opcode 1)
// then skips, ends the sprite, fills a run or steps to the next row, giving at most one
// result word. Each word is registered at the input, decoded in one pass against the column,
// row and edge registers, and its result goes into a three-entry output queue, so one word
// per cycle is sustained while out_stall is low; the input keeps accepting while a result
// waits, until queue and input register are full. Configuration is written via cfg_valid/
// cfg_ready (always ready), by the user only while idle; the block does not enforce it.
module mirrored_rle_sprite_run_blitter_top
    import mrsb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  in_word_t                in_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output out_word_t               out_data,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [15:0]             cfg_data
);

    clip_cfg_t           cfg_reg, cfg_next;
    logic                item_valid_reg;
    in_word_t            item_reg;
    logic                res_valid;
    out_word_t           res;
    logic [CNT_BITS-1:0] queue_count;
    logic [CNT_BITS:0]   pending;

    assign cfg_ready = 1'b1;

    // queue space must cover the word held in the input register as well
    assign pending  = {1'b0, queue_count} + (CNT_BITS+1)'(item_valid_reg);
    assign in_stall = (pending >= (CNT_BITS+1)'(FIFO_DEPTH));

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CLIP_ENABLE: cfg_next.clip_enable = cfg_data[0];
                REG_CLIP_LEFT:   cfg_next.clip_left   = cfg_data;
                REG_CLIP_TOP:    cfg_next.clip_top    = cfg_data;
                REG_CLIP_WIDTH:  cfg_next.clip_width  = cfg_data[14:0];
                REG_CLIP_HEIGHT: cfg_next.clip_height = cfg_data[14:0];
                // palette index belongs to the pixel writer, no run depends on it
                REG_FILL_COLOR:  cfg_next = cfg_reg;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clip_enable <= 1'b0;
            cfg_reg.clip_left   <= '0;
            cfg_reg.clip_top    <= '0;
            cfg_reg.clip_width  <= 15'd640;
            cfg_reg.clip_height <= 15'd480;
            item_valid_reg      <= 1'b0;
        end
        else
        begin
            cfg_reg        <= cfg_next;
            item_valid_reg <= in_valid && !in_stall;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            item_reg <= in_data;
    end

    mrsb_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid_reg),
        .item       (item_reg),
        .cfg        (cfg_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    mrsb_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop       (!out_stall),
        .not_empty (out_valid),
        .head      (out_data),
        .count     (queue_count)
    );

endmodule

// ===== rtl/mrsb_checker.sv =====
module mrsb_checker
    import mrsb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_word_t out_data
);

    // an end word carries no run
    a_end_word_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.end_of_sprite |->
            out_data.fill_length == '0 && out_data.fill_x == '0 && out_data.fill_y == '0)
        else $error("end word carries run data");

    // a fill run is never zero long
    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.end_of_sprite |-> out_data.fill_length != '0)
        else $error("fill run of zero length");

    // no result appears without a word accepted before it
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !(in_valid && !in_stall) && !$past(in_valid && !in_stall) |=>
            !out_valid)
        else $error("result without an accepted word");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

endmodule

bind mirrored_rle_sprite_run_blitter_top mrsb_checker u_mrsb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
